### rtl/bxf_pkg.sv
// Shared types and constants of the separable 5x5 box filter.
package bxf_pkg;

	localparam int PIX_W      = 8;
	localparam int KERNEL     = 5;
	localparam int LINE_CNT   = KERNEL - 1;
	localparam int HALF_K     = KERNEL / 2;
	localparam int WORD_W     = PIX_W * LINE_CNT;
	localparam int SLOT_W     = $clog2(LINE_CNT);
	localparam int SUM_W      = 11;
	localparam int TOTAL_W    = 13;
	localparam int POS_W      = 13;
	localparam int CFG_W      = 14;
	localparam int IDX_W      = 1;
	localparam int MIN_SIZE   = 5;
	localparam int MAX_HEIGHT = 8192;
	localparam int VALUE_W    = 16;
	localparam int TDATA_W    = 48;

	// floor(total * 256 / 25) == (total * RECIP_M) >> RECIP_SH, exact for total <= 6375
	localparam int RECIP_W  = 22;
	localparam logic [RECIP_W-1:0] RECIP_M = 22'd2684355;
	localparam int RECIP_SH = 18;
	localparam int PROD_W   = TOTAL_W + RECIP_W;

	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	typedef struct packed {
		logic [POS_W-1:0]  center_row;
		logic [POS_W-1:0]  center_col;
		logic [SLOT_W-1:0] slot;
		logic              produce;
		logic              last;
	} meta_t;

endpackage

### rtl/bxf_line_mem.sv
// Line store: one word per column holding the pixels of the last four rows.
module bxf_line_mem #(
	parameter int DEPTH  = 8192,
	parameter int ADDR_W = 13,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/bxf_scan.sv
// Raster position tracker and frame size registers.
module bxf_scan #(
	parameter int MAX_WIDTH = 8192,
	parameter int COL_W     = 13
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [bxf_pkg::IDX_W-1:0] cfg_index,
	input  logic [bxf_pkg::CFG_W-1:0] cfg_data,
	input  logic                     step,
	input  logic                     frame_start,
	output logic [COL_W-1:0]         col,
	output bxf_pkg::meta_t           meta
);
	import bxf_pkg::*;

	localparam int LIM_W = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W = (LIM_W > CFG_W) ? LIM_W : CFG_W;

	logic [CFG_W-1:0] width_q, height_q;
	logic [COL_W-1:0] col_q;
	logic [POS_W-1:0] row_q;

	logic [CMP_W-1:0] w_eff;
	logic [CFG_W-1:0] h_eff;
	logic [COL_W-1:0] col0, col1;
	logic [POS_W-1:0] row0, row1, row;
	logic [CFG_W-1:0] row0_inc, row_inc;
	logic [CMP_W-1:0] col_inc, col_off;
	logic [POS_W-1:0] row_off;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(8192);
			height_q <= CFG_W'(8192);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < CFG_W'(MIN_SIZE))
			w_eff = CMP_W'(MIN_SIZE);
		else if (CMP_W'(width_q) > CMP_W'(MAX_WIDTH))
			w_eff = CMP_W'(MAX_WIDTH);
		else
			w_eff = CMP_W'(width_q);
		if (height_q < CFG_W'(MIN_SIZE))
			h_eff = CFG_W'(MIN_SIZE);
		else if (height_q > CFG_W'(MAX_HEIGHT))
			h_eff = CFG_W'(MAX_HEIGHT);
		else
			h_eff = height_q;
	end

	// settle the position of the arriving item: restart, row overrun, frame wrap
	always_comb begin
		col0     = frame_start ? '0 : col_q;
		row0     = frame_start ? '0 : row_q;
		row0_inc = CFG_W'(row0) + CFG_W'(1);
		if (CMP_W'(col0) >= w_eff) begin
			col1 = '0;
			row1 = row0_inc[POS_W-1:0];
		end else begin
			col1 = col0;
			row1 = row0;
		end
		if (CMP_W'(col0) >= w_eff && row0_inc >= h_eff)
			row = '0;
		else if (CFG_W'(row1) >= h_eff)
			row = '0;
		else
			row = row1;
		col     = col1;
		col_inc = CMP_W'(col1) + CMP_W'(1);
		row_inc = CFG_W'(row) + CFG_W'(1);
		col_off = CMP_W'(col1) - CMP_W'(HALF_K);
		row_off = row - POS_W'(HALF_K);

		meta.center_row = row_off;
		meta.center_col = col_off[POS_W-1:0];
		meta.slot       = row[SLOT_W-1:0];
		meta.produce    = (row >= POS_W'(LINE_CNT)) && (CMP_W'(col1) >= CMP_W'(LINE_CNT));
		meta.last       = (row_inc == h_eff) && (col_inc == w_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (col_inc >= w_eff) begin
				col_q <= '0;
				row_q <= (row_inc >= h_eff) ? '0 : row_inc[POS_W-1:0];
			end else begin
				col_q <= col_inc[COL_W-1:0];
				row_q <= row;
			end
		end
	end

endmodule

### rtl/bxf_mean.sv
// Output stage: scales the 25-pixel sum to an 8.8 mean and holds the result.
module bxf_mean (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic                       drain,
	input  logic [bxf_pkg::TOTAL_W-1:0] total,
	input  logic [bxf_pkg::POS_W-1:0]  center_row,
	input  logic [bxf_pkg::POS_W-1:0]  center_col,
	input  logic                       last,
	output logic                       out_valid,
	output logic [bxf_pkg::TDATA_W-1:0] out_data,
	output logic                       out_last
);
	import bxf_pkg::*;

	logic [PROD_W-1:0]  prod;
	logic [VALUE_W-1:0] value_q;
	logic [POS_W-1:0]   row_q, col_q;
	logic               valid_q, last_q;

	assign prod = PROD_W'(total) * PROD_W'(RECIP_M);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (drain) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= prod[RECIP_SH +: VALUE_W];
			row_q   <= center_row;
			col_q   <= center_col;
			last_q  <= last;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = {{(TDATA_W - VALUE_W - 2*POS_W){1'b0}}, col_q, row_q, value_q};
	assign out_last  = last_q;

endmodule

### rtl/box_filter_5x5_separable_core.sv
// Top level of the separable 5x5 box filter core.
// Takes one pixel a clock in raster order and returns the 5x5 mean of each interior pixel
// (rows and columns 2 to size minus 3) in unsigned 8.8, tagged with its row and column;
// border pixels give no result, and tlast marks the result of the frame's last pixel.
// A result passes stages 1, 2 and 3 and then the output register. The rate of one item per clock
// is set by the line store, a memory of MAX_WIDTH words of four packed pixels with one
// read and one write port: each pixel reads its column word, adds the four stored pixels
// to itself and writes the word back with the oldest row replaced. A bypass covers a word
// read in the same clock as it is written. The store is not cleared; after a frame start
// no result draws on it until four fresh rows have passed. The input stalls only when a
// result reaches the last stage while the output register still holds one not taken.
// Sizes are written through cfg_we/cfg_index/cfg_data (0: width, 1: height) while idle;
// values outside 5..MAX_WIDTH and 5..8192 are clamped.
module box_filter_5x5_separable_core #(
	parameter int MAX_WIDTH = 8192
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bxf_pkg::IDX_W-1:0]   cfg_index,
	input  logic [bxf_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] pixel_value
	input  logic                        s_tuser,   // [0] frame_start
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [bxf_pkg::TDATA_W-1:0] m_tdata,   // [15:0] filtered_value, [28:16] center_row,
	                                               // [41:29] center_col, [47:42] zero
	output logic                        m_tlast    // frame_done
);
	import bxf_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);

	logic             accept, stall, adv;
	logic [COL_W-1:0] col;
	meta_t            meta;

	// stage 1: line store word arrives
	logic             valid_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [COL_W-1:0] col_s1;
	meta_t            meta_s1;
	logic [WORD_W-1:0] rd_word, word, new_word;
	logic [SUM_W-1:0]  colsum;

	// last write, for the bypass
	logic              wr_valid_q;
	logic [COL_W-1:0]  wr_addr_q;
	logic [WORD_W-1:0] wr_data_q;

	// stage 2: column sum into the window
	logic             valid_s2;
	logic [SUM_W-1:0] colsum_s2;
	meta_t            meta_s2;
	logic [SUM_W-1:0] win_q [LINE_CNT];
	logic [TOTAL_W-1:0] total;

	// stage 3: window total
	logic               valid_s3;
	logic [TOTAL_W-1:0] total_s3;
	meta_t              meta_s3;

	// hold everything while a result waits for a full output register
	assign stall    = valid_s3 && meta_s3.produce && m_tvalid && !m_tready;
	assign adv      = !stall;
	assign s_tready = adv;
	assign accept   = s_tvalid && s_tready;

	bxf_scan #(
		.MAX_WIDTH(MAX_WIDTH),
		.COL_W    (COL_W)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.step       (accept),
		.frame_start(s_tuser),
		.col        (col),
		.meta       (meta)
	);

	bxf_line_mem #(
		.DEPTH (MAX_WIDTH),
		.ADDR_W(COL_W),
		.DATA_W(WORD_W)
	) u_line_mem (
		.clk    (clk),
		.rd_en  (accept),
		.rd_addr(col),
		.rd_data(rd_word),
		.wr_en  (valid_s1 && adv),
		.wr_addr(col_s1),
		.wr_data(new_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			wr_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			if (valid_s1) begin
				wr_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1    <= s_tdata;
			col_s1    <= col;
			meta_s1   <= meta;
			colsum_s2 <= colsum;
			meta_s2   <= meta_s1;
			total_s3  <= total;
			meta_s3   <= meta_s2;
			if (valid_s1) begin
				wr_addr_q <= col_s1;
				wr_data_q <= new_word;
			end
		end
	end

	// take the word just written when the read raced it
	always_comb begin
		word = (wr_valid_q && wr_addr_q == col_s1) ? wr_data_q : rd_word;
		colsum = SUM_W'(pix_s1);
		for (int i = 0; i < LINE_CNT; i++) begin
			colsum = colsum + SUM_W'(word[i*PIX_W +: PIX_W]);
			new_word[i*PIX_W +: PIX_W] = (SLOT_W'(i) == meta_s1.slot) ?
				pix_s1 : word[i*PIX_W +: PIX_W];
		end
	end

	// window of column sums: the newest plus the four before it
	always_comb begin
		total = TOTAL_W'(colsum_s2);
		for (int i = 0; i < LINE_CNT; i++) begin
			total = total + TOTAL_W'(win_q[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LINE_CNT; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv && valid_s2) begin
			for (int i = 0; i < LINE_CNT - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[LINE_CNT-1] <= colsum_s2;
		end
	end

	bxf_mean u_mean (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && valid_s3 && meta_s3.produce),
		.drain     (m_tready),
		.total     (total_s3),
		.center_row(meta_s3.center_row),
		.center_col(meta_s3.center_col),
		.last      (meta_s3.last),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

### rtl/bxf_checker.sv
// Port-level checks of the box filter core, bound to its top level.
module bxf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tlast
);

	// a result held back keeps its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// the mean of 8-bit pixels never exceeds 255.0
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:0] <= 16'hFF00)
		else $error("mean out of range");

	// results lie at row and column 2 or above, padding stays zero
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[28:16] >= 13'd2 && m_tdata[41:29] >= 13'd2
			&& m_tdata[47:42] == 6'd0)
		else $error("border or malformed result");

	// an offered item is refused only while a result waits on the output
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |-> m_tvalid && !m_tready)
		else $error("input refused with the output free");

	// nothing leaves in the clock after reset is seen
	a_reset: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result during reset");

endmodule

bind box_filter_5x5_separable_core bxf_checker u_bxf_checker (.*);
